/* sv/mdsc_pkg.sv */
// Package for min_descending_split_count: table size, index widths, state codes
// and the beat types of both channels. No dependencies.
package mdsc_pkg;

    localparam int MAX_PILES = 256;
    localparam int IDX_W     = $clog2(MAX_PILES + 1);
    localparam int ADDR_W    = $clog2(MAX_PILES);
    localparam int VALUE_W   = 32;
    localparam int COUNT_W   = 9;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      last;
    } in_beat_t;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic               final_res;
        logic               overflow;
    } out_beat_t;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_START = 4'b0010,
        S_CMP   = 4'b0100,
        S_WRITE = 4'b1000
    } state_t;

endpackage

/* sv/min_descending_split_count.sv */
// min_descending_split_count: patience-sort pile counter over a tail RAM.
// Flow: S_IDLE takes a beat, S_START reads the first tail when any piles exist, S_CMP does
// one search step per read (up to log2(MAX_PILES)+1 steps), S_WRITE updates the table and
// output register; one item at a time, next beat taken back in S_IDLE, later while a result is held.
// Reset: asynchronous, clears pile count, overflow flag and control; the tail RAM
// is not cleared and is only read below the pile count.
module min_descending_split_count
    import mdsc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_beat_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_beat_t out_data
);

    logic signed [VALUE_W-1:0] tails_mem [0:MAX_PILES-1];
    logic signed [VALUE_W-1:0] rd_data_reg;
    logic                      rd_en;
    logic [ADDR_W-1:0]         rd_addr;
    logic                      wr_en;
    logic [ADDR_W-1:0]         wr_addr;

    state_t             state_reg, state_next;
    in_beat_t           item_reg, item_next;
    logic [IDX_W-1:0]   lo_reg, lo_next;
    logic [IDX_W-1:0]   hi_reg, hi_next;
    logic [IDX_W-1:0]   mid_reg, mid_next;
    logic [IDX_W-1:0]   tail_count_reg, tail_count_next;
    logic               overflow_reg, overflow_next;
    logic               out_valid_reg, out_valid_next;
    out_beat_t          out_data_reg, out_data_next;

    logic [IDX_W-1:0]   mid_start;
    logic [IDX_W-1:0]   lo_cmp, hi_cmp, mid_cmp;
    logic [IDX_W-1:0]   tail_after;
    logic               overflow_after;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign mid_start = lo_reg + ((hi_reg - lo_reg) >> 1);

    always_comb
    begin
        if (rd_data_reg > item_reg.value)
        begin
            lo_cmp = lo_reg;
            hi_cmp = mid_reg;
        end
        else
        begin
            lo_cmp = mid_reg + IDX_W'(1);
            hi_cmp = hi_reg;
        end
        mid_cmp = lo_cmp + ((hi_cmp - lo_cmp) >> 1);
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            tails_mem[wr_addr] <= item_reg.value;
        end
        if (rd_en)
        begin
            rd_data_reg <= tails_mem[rd_addr];
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        item_next       = item_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        mid_next        = mid_reg;
        tail_count_next = tail_count_reg;
        overflow_next   = overflow_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_data_next   = out_data_reg;
        rd_en           = 1'b0;
        rd_addr         = mid_start[ADDR_W-1:0];
        wr_en           = 1'b0;
        wr_addr         = lo_reg[ADDR_W-1:0];
        tail_after      = tail_count_reg;
        overflow_after  = overflow_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    item_next  = in_data;
                    lo_next    = '0;
                    hi_next    = tail_count_reg;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                if (lo_reg < hi_reg)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = mid_start[ADDR_W-1:0];
                    mid_next   = mid_start;
                    state_next = S_CMP;
                end
                else
                begin
                    state_next = S_WRITE;
                end
            end
            S_CMP:
            begin
                lo_next = lo_cmp;
                hi_next = hi_cmp;
                if (lo_cmp < hi_cmp)
                begin
                    rd_en    = 1'b1;
                    rd_addr  = mid_cmp[ADDR_W-1:0];
                    mid_next = mid_cmp;
                end
                else
                begin
                    state_next = S_WRITE;
                end
            end
            S_WRITE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    if (lo_reg < tail_count_reg)
                    begin
                        wr_en = 1'b1;
                    end
                    else if (tail_count_reg < IDX_W'(MAX_PILES))
                    begin
                        wr_en      = 1'b1;
                        tail_after = tail_count_reg + IDX_W'(1);
                    end
                    else
                    begin
                        overflow_after = 1'b1;
                    end
                    out_valid_next          = 1'b1;
                    out_data_next.count     = COUNT_W'(tail_after);
                    out_data_next.final_res = item_reg.last;
                    out_data_next.overflow  = overflow_after;
                    if (item_reg.last)
                    begin
                        tail_count_next = '0;
                        overflow_next   = 1'b0;
                    end
                    else
                    begin
                        tail_count_next = tail_after;
                        overflow_next   = overflow_after;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            tail_count_reg <= '0;
            overflow_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            tail_count_reg <= tail_count_next;
            overflow_reg   <= overflow_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        mid_reg      <= mid_next;
        out_data_reg <= out_data_next;
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        tail_count_reg <= IDX_W'(MAX_PILES))
        else $error("pile count beyond table size");

    a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
        overflow_reg |-> (tail_count_reg == IDX_W'(MAX_PILES)))
        else $error("overflow flagged with table not full");

    a_search_window: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CMP) |-> (lo_reg < hi_reg && hi_reg <= tail_count_reg))
        else $error("search window outside live tails");
`endif

endmodule

/* verif/min_descending_split_count_test.sv */
// Self-checking testbench for min_descending_split_count: directed and random value
// streams, each result beat checked against a pile-tail predictor held here.
// Depends on mdsc_pkg and the min_descending_split_count RTL.
module min_descending_split_count_test
    import mdsc_pkg::*;
();

    localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    in_beat_t  in_data   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_beat_t out_data;

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned mismatch_count = 0;

    logic signed [VALUE_W-1:0] pile_tails [MAX_PILES];
    int unsigned               pile_count = 0;
    bit                        overflow_sticky = 1'b0;
    out_beat_t                 pending_counts [$];

    min_descending_split_count dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_idle_pct);

    // Patience sort: replace first tail strictly above the value, else open a pile
    function automatic void track_piles(in_beat_t item);
        int unsigned               lo;
        int unsigned               hi;
        int unsigned               mid;
        logic signed [VALUE_W-1:0] v;
        out_beat_t                 res;
        v  = item.value;
        lo = 0;
        hi = pile_count;
        while (lo < hi)
        begin
            mid = lo + (hi - lo) / 2;
            if (pile_tails[mid] > v)
                hi = mid;
            else
                lo = mid + 1;
        end
        if (lo < pile_count)
            pile_tails[lo] = v;
        else if (pile_count < MAX_PILES)
        begin
            pile_tails[pile_count] = v;
            pile_count++;
        end
        else
            overflow_sticky = 1'b1;
        res.count     = pile_count[COUNT_W-1:0];
        res.final_res = item.last;
        res.overflow  = overflow_sticky;
        pending_counts = {pending_counts, res};
        if (item.last)
        begin
            pile_count      = 0;
            overflow_sticky = 1'b0;
        end
    endfunction

    function automatic void note_mismatch(string field, int unsigned want, int unsigned got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
    endfunction

    always @(posedge clk)
    begin : check_results
        out_beat_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_counts.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: unexpected result beat, count %0d", $time, out_data.count);
            end
            else
            begin
                want = pending_counts.pop_front();
                if (out_data.count !== want.count)
                    note_mismatch("count", want.count, out_data.count);
                if (out_data.final_res !== want.final_res)
                    note_mismatch("final_res", want.final_res, out_data.final_res);
                if (out_data.overflow !== want.overflow)
                    note_mismatch("overflow", want.overflow, out_data.overflow);
            end
        end
    end

    // Called just after a rising edge; valid stays up between back-to-back beats
    task automatic send_item(input logic signed [VALUE_W-1:0] value, input logic last);
        in_beat_t item;
        item.value = value;
        item.last  = last;
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        track_piles(item);
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (pending_counts.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_single_items();
        send_item(32'sd7, 1'b1);
        send_item(VAL_MIN, 1'b1);
        send_item(VAL_MAX, 1'b1);
    endtask

    task automatic test_extremes();
        send_item(VAL_MAX, 1'b0);
        send_item(VAL_MIN, 1'b0);
        send_item(32'sd0, 1'b0);
        send_item(-32'sd1, 1'b0);
        send_item(VAL_MIN, 1'b0);
        send_item(VAL_MAX, 1'b0);
        send_item(VAL_MAX, 1'b0);
        send_item(32'sd0, 1'b1);
        // equal values each start a new descending run
        repeat (4)
            send_item(-32'sd5, 1'b0);
        send_item(-32'sd5, 1'b1);
    endtask

    task automatic test_descending_runs();
        send_item(VAL_MAX, 1'b0);
        send_item(32'sd100, 1'b0);
        send_item(32'sd0, 1'b0);
        send_item(-32'sd100, 1'b0);
        send_item(VAL_MIN, 1'b1);
        wait_for_results();
    endtask

    task automatic test_table_full();
        for (int i = 0; i < MAX_PILES + 2; i++)
            send_item(i * 3 - 400, 1'b0);
        // replace after overflow: flag must stay set
        send_item(-32'sd1000, 1'b0);
        send_item(VAL_MAX, 1'b1);
        send_item(32'sd5, 1'b1);
        wait_for_results();
    endtask

    task automatic test_random_mix(input int target, input int unsigned send_pct,
                                   input int unsigned recv_pct);
        int sent;
        int kind;
        int len;
        int base;
        int step;
        int v;
        logic last_flag;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        sent = 0;
        while (sent < target)
        begin
            kind = $urandom_range(9);
            len  = (kind == 4 || kind == 5) ? $urandom_range(1, 150) : $urandom_range(1, 40);
            base = int'($urandom_range(65535)) - 32768;
            step = $urandom_range(1000);
            for (int i = 0; i < len; i++)
            begin
                last_flag = (i == len - 1);
                case (kind)
                    0, 1: v = $urandom;
                    2, 3: v = int'($urandom_range(15)) - 8;
                    4, 5: v = ($urandom_range(9) == 0) ? int'($urandom) : base + i * step;
                    6:    v = base - i * step;
                    7:    v = base;
                    8:
                    begin
                        v         = $urandom;
                        last_flag = ($urandom_range(7) == 0);
                    end
                    default:
                        case ($urandom_range(4))
                            0:       v = VAL_MIN;
                            1:       v = VAL_MAX;
                            2:       v = 0;
                            3:       v = -1;
                            default: v = $urandom;
                        endcase
                endcase
                send_item(v, last_flag);
                sent++;
            end
            if ($urandom_range(7) == 0)
                wait_for_results();
        end
        wait_for_results();
    endtask

    initial
    begin
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_idle_pct = 24;
        recv_idle_pct = 58;
        test_single_items();
        test_extremes();
        test_descending_runs();
        test_table_full();
        test_random_mix(250, 24, 58);
        test_random_mix(250, 58, 24);
        test_random_mix(250, 0, 0);
        repeat (30)
            @(posedge clk);
        if (mismatch_count == 0 && pending_counts.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("Mismatches found");
        $finish;
    end

endmodule
